// ===== design/bhc_pkg.sv =====
// shared constants, types and helpers for the bucket histogram counter
package bhc_pkg;

    localparam int MAX_BOUNDS  = 7;
    localparam int TALLY_WIDTH = 40;
    localparam int DEPTH       = MAX_BOUNDS + 1;
    localparam int BKT_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ADD_W       = (TALLY_WIDTH > 32) ? TALLY_WIDTH : 32;
    localparam int OUT_CNT_W   = 40;
    localparam int CLAMP_W     = (TALLY_WIDTH > OUT_CNT_W) ? TALLY_WIDTH : OUT_CNT_W;

    typedef logic [TALLY_WIDTH-1:0] tally_t;
    typedef logic [BKT_W-1:0]       bkt_t;

    typedef enum logic [1:0] {
        CMD_OBSERVE = 2'd0,
        CMD_BULK    = 2'd1,
        CMD_COLLECT = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_e;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_READ,
        ST_EMIT
    } state_t;

    localparam logic [2:0] REG_BOUND_COUNT = 3'd0;
    localparam logic [2:0] REG_BOUND_FIRST = 3'd1;

    localparam tally_t TALLY_MAX = '1;

    // saturating add of a count onto a tally
    function automatic tally_t sat_tally(input tally_t base, input logic [ADD_W-1:0] amt);
        logic [ADD_W:0] sum;
        begin
            sum = (ADD_W+1)'(base) + (ADD_W+1)'(amt);
            if (sum > (ADD_W+1)'(TALLY_MAX)) begin
                sat_tally = TALLY_MAX;
            end else begin
                sat_tally = TALLY_WIDTH'(sum);
            end
        end
    endfunction

    // clamp a tally onto the fixed output count width
    function automatic logic [OUT_CNT_W-1:0] clamp_count(input tally_t v);
        logic [CLAMP_W-1:0] ext;
        logic [CLAMP_W-1:0] lim;
        begin
            ext = CLAMP_W'(v);
            lim = CLAMP_W'({OUT_CNT_W{1'b1}});
            if (ext > lim) begin
                clamp_count = {OUT_CNT_W{1'b1}};
            end else begin
                clamp_count = OUT_CNT_W'(ext);
            end
        end
    endfunction

endpackage

// ===== design/bucket_histogram_counter_core.sv =====
// bucket histogram counter: tally memory, update pipeline and collect sequencer
//
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    cmd, sample_value, target_bucket, add_amount
//  m_       out        m_valid / m_ready    one bucket report per transaction
//  cfg_     in         cfg_valid/cfg_ready  register index and write data
//
// observe, bulk add and clear may follow back to back:
// the tally memory is read on acceptance and written in the following cycle, with a
// forwarding path for a hit on the entry just written.
// collect handles each bucket as a memory read, then an emit that waits out any m_ready stall;
// no input transaction is taken until the last report is loaded.
// aresetn is synchronous; clearing uses one valid bit per tally entry, so no sweep.
module bucket_histogram_counter_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic signed [31:0] s_sample_value,
    input  logic [2:0]         s_target_bucket,
    input  logic [31:0]        s_add_amount,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_bucket_number,
    output logic [39:0]        m_running_count,
    output logic signed [31:0] m_upper_limit,
    output logic               m_limit_infinite,
    output logic signed [63:0] m_total_sum,
    output logic               m_last_flag,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import bhc_pkg::*;

    // configuration
    logic [2:0]         bound_count_reg;
    logic signed [31:0] bound_reg [DEPTH];
    logic [2:0]         nb;

    // tally memory and per-entry valid bits
    tally_t             tally_mem [DEPTH];
    logic [DEPTH-1:0]   ent_valid_reg;
    tally_t             rd_data_reg;
    logic               rd_valid_reg;
    logic               rd_en;
    bkt_t               rd_addr;

    // update stage
    logic               p1_valid_reg;
    logic               p1_clear_reg;
    bkt_t               p1_addr_reg;
    logic [31:0]        p1_amount_reg;
    logic signed [31:0] p1_value_reg;
    logic               fwd_en_reg;
    logic               fwd_clear_reg;
    bkt_t               fwd_addr_reg;
    tally_t             fwd_data_reg;
    tally_t             old_tally;
    tally_t             new_tally;
    logic signed [63:0] sum_reg;
    logic signed [64:0] sum_wide;
    logic signed [63:0] sum_sat;

    // accept side
    logic               s_acc;
    logic               upd_go;
    logic               drop;
    bkt_t               obs_idx;
    bkt_t               upd_addr;

    // collect sequencer
    state_t             state_reg;
    state_t             state_next;
    bkt_t               col_idx_reg;
    tally_t             cum_reg;
    tally_t             cum_new;
    logic               col_last;
    logic               slot_free;
    logic               emit_load;

    // output register
    logic               m_valid_reg;
    logic [2:0]         m_bucket_reg;
    logic [39:0]        m_count_reg;
    logic signed [31:0] m_limit_reg;
    logic               m_inf_reg;
    logic signed [63:0] m_sum_reg;
    logic               m_last_reg;

    assign nb        = (bound_count_reg > 3'(MAX_BOUNDS)) ? 3'(MAX_BOUNDS) : bound_count_reg;
    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_RUN);
    assign s_acc     = s_valid && s_ready;

    // bucket index: number of active bounds strictly below the value
    always_comb begin
        obs_idx = '0;
        for (int i = 0; i < MAX_BOUNDS; i++) begin
            if ((3'(i) < nb) && (bound_reg[i] < s_sample_value)) begin
                obs_idx = obs_idx + bkt_t'(1);
            end
        end
    end

    assign drop     = (s_target_bucket > nb);
    assign upd_addr = (s_cmd == CMD_OBSERVE) ? obs_idx : BKT_W'(s_target_bucket);
    assign upd_go   = s_acc && ((s_cmd == CMD_OBSERVE) || ((s_cmd == CMD_BULK) && !drop));

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bound_count_reg <= '0;
            for (int i = 0; i < DEPTH; i++) begin
                bound_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_BOUND_COUNT) begin
                bound_count_reg <= cfg_data[2:0];
            end else if ((cfg_index - REG_BOUND_FIRST) < 3'(MAX_BOUNDS)) begin
                bound_reg[BKT_W'(cfg_index - REG_BOUND_FIRST)] <= cfg_data;
            end
        end
    end

    // read-modify-write with forwarding from the write or clear just committed
    always_comb begin
        if (fwd_en_reg && fwd_clear_reg) begin
            old_tally = '0;
        end else if (fwd_en_reg && (fwd_addr_reg == p1_addr_reg)) begin
            old_tally = fwd_data_reg;
        end else if (rd_valid_reg) begin
            old_tally = rd_data_reg;
        end else begin
            old_tally = '0;
        end
    end

    assign new_tally = sat_tally(old_tally, ADD_W'(p1_amount_reg));
    assign sum_wide  = {sum_reg[63], sum_reg} + 65'(p1_value_reg);
    assign sum_sat   = (sum_wide[64] != sum_wide[63])
                     ? (sum_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}})
                     : sum_wide[63:0];

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= tally_mem[rd_addr];
        end
        if (p1_valid_reg && !p1_clear_reg) begin
            tally_mem[p1_addr_reg] <= new_tally;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            fwd_en_reg    <= 1'b0;
            ent_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            sum_reg       <= '0;
        end else begin
            p1_valid_reg <= upd_go || (s_acc && (s_cmd == CMD_CLEAR));
            fwd_en_reg   <= p1_valid_reg;
            if (rd_en) begin
                rd_valid_reg <= ent_valid_reg[rd_addr];
            end
            if (p1_valid_reg && p1_clear_reg) begin
                ent_valid_reg <= '0;
                sum_reg       <= '0;
            end else if (p1_valid_reg) begin
                ent_valid_reg[p1_addr_reg] <= 1'b1;
                sum_reg                    <= sum_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        p1_clear_reg  <= (s_cmd == CMD_CLEAR);
        p1_addr_reg   <= upd_addr;
        p1_amount_reg <= (s_cmd == CMD_OBSERVE) ? 32'd1 : s_add_amount;
        p1_value_reg  <= s_sample_value;
        fwd_clear_reg <= p1_clear_reg;
        fwd_addr_reg  <= p1_addr_reg;
        fwd_data_reg  <= new_tally;
    end

    // collect sequencer: next state
    assign col_last  = (3'(col_idx_reg) == nb);
    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN: begin
                if (s_acc && (s_cmd == CMD_COLLECT)) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    state_next = col_last ? ST_RUN : ST_READ;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    // collect sequencer: outputs
    always_comb begin
        rd_en     = 1'b0;
        rd_addr   = upd_addr;
        emit_load = 1'b0;
        unique case (state_reg)
            ST_RUN: begin
                rd_en = upd_go;
            end
            ST_READ: begin
                rd_en   = 1'b1;
                rd_addr = col_idx_reg;
            end
            ST_EMIT: begin
                emit_load = slot_free;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // pipeline is empty in emit, so the registered read is current
    assign cum_new = sat_tally(cum_reg, ADD_W'(rd_valid_reg ? rd_data_reg : tally_t'(0)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            col_idx_reg <= '0;
            cum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_acc && (s_cmd == CMD_COLLECT)) begin
                col_idx_reg <= '0;
                cum_reg     <= '0;
            end else if (emit_load) begin
                col_idx_reg <= col_idx_reg + bkt_t'(1);
                cum_reg     <= cum_new;
            end
            if (emit_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_load) begin
            m_bucket_reg <= 3'(col_idx_reg);
            m_count_reg  <= clamp_count(cum_new);
            m_limit_reg  <= col_last ? 32'sd0 : bound_reg[col_idx_reg];
            m_inf_reg    <= col_last;
            m_sum_reg    <= col_last ? sum_reg : 64'sd0;
            m_last_reg   <= col_last;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_bucket_number  = m_bucket_reg;
    assign m_running_count  = m_count_reg;
    assign m_upper_limit    = m_limit_reg;
    assign m_limit_infinite = m_inf_reg;
    assign m_total_sum      = m_sum_reg;
    assign m_last_flag      = m_last_reg;

    // a clear leaves every tally entry reading as zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && p1_clear_reg) |=> (ent_valid_reg == '0))
        else $error("tally valid bits not cleared");

    // collect reads only once the update stage has drained
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> !p1_valid_reg)
        else $error("collect read overlaps a pending tally write");

    // a stalled report holds the sequencer in emit
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EMIT) && m_valid_reg && !m_ready) |=> (state_reg == ST_EMIT))
        else $error("report loaded over a stalled transaction");

    // only the last report carries the open bucket and the sum
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |-> (!m_inf_reg && (m_sum_reg == 64'sd0)))
        else $error("sum or open bucket on a report that is not last");

endmodule
